FILE: src/mnnsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnnsd_pkg
// Shared widths, constants, control word layout and the microprogram of the
// mean nearest neighbor squared distance core.
// ----------------------------------------------------------------------------
package mnnsd_pkg;

  localparam int MAX_POINTS = 256;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int REM_W      = ADDR_W + 1;

  localparam int COORD_W = 16;
  localparam int POINT_W = 3 * COORD_W;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int DIST_W  = 34;
  localparam int SUM_W   = DIST_W + ADDR_W;
  localparam int DCNT_W  = $clog2(SUM_W);

  localparam logic [DIST_W-1:0] MEAN_SAT = 34'd12884508675;

  localparam int PC_W = 4;

  // step addresses of the microprogram
  localparam logic [PC_W-1:0] S_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] S_CHK   = 4'd1;
  localparam logic [PC_W-1:0] S_RDI   = 4'd2;
  localparam logic [PC_W-1:0] S_LATI  = 4'd3;
  localparam logic [PC_W-1:0] S_RDJ   = 4'd4;
  localparam logic [PC_W-1:0] S_DIFF  = 4'd5;
  localparam logic [PC_W-1:0] S_SQ    = 4'd6;
  localparam logic [PC_W-1:0] S_CMP   = 4'd7;
  localparam logic [PC_W-1:0] S_ACC   = 4'd8;
  localparam logic [PC_W-1:0] S_DINIT = 4'd9;
  localparam logic [PC_W-1:0] S_DSTEP = 4'd10;
  localparam logic [PC_W-1:0] S_LONE  = 4'd11;
  localparam logic [PC_W-1:0] S_OUT   = 4'd12;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_LAST,
    C_LONE,
    C_J_END,
    C_I_END,
    C_DIV_END,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    logic            in_rdy;
    logic            ld_pi;
    logic            rd_j;
    logic            init_i;
    logic            init_j;
    logic            inc_j;
    logic            inc_i;
    logic            diff_en;
    logic            sq_en;
    logic            cmp_en;
    logic            acc_en;
    logic            div_init;
    logic            div_step;
    logic            lone_ld;
    logic            out_ld;
    cond_t           cond;
    logic [PC_W-1:0] tgt_t;
    logic [PC_W-1:0] tgt_f;
  } ucode_t;

  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '0;
    w.cond = C_ALWAYS;
    unique case (pc)
      S_IDLE: begin
        w.in_rdy = 1'b1;
        w.cond = C_LAST;
        w.tgt_t = S_CHK;
        w.tgt_f = S_IDLE;
      end
      S_CHK: begin
        w.init_i = 1'b1;
        w.cond = C_LONE;
        w.tgt_t = S_LONE;
        w.tgt_f = S_RDI;
      end
      S_RDI: begin
        w.init_j = 1'b1;
        w.tgt_t = S_LATI;
      end
      S_LATI: begin
        w.ld_pi = 1'b1;
        w.tgt_t = S_RDJ;
      end
      S_RDJ: begin
        w.rd_j = 1'b1;
        w.tgt_t = S_DIFF;
      end
      S_DIFF: begin
        w.diff_en = 1'b1;
        w.tgt_t = S_SQ;
      end
      S_SQ: begin
        w.sq_en = 1'b1;
        w.tgt_t = S_CMP;
      end
      S_CMP: begin
        w.cmp_en = 1'b1;
        w.inc_j = 1'b1;
        w.cond = C_J_END;
        w.tgt_t = S_ACC;
        w.tgt_f = S_RDJ;
      end
      S_ACC: begin
        w.acc_en = 1'b1;
        w.inc_i = 1'b1;
        w.cond = C_I_END;
        w.tgt_t = S_DINIT;
        w.tgt_f = S_RDI;
      end
      S_DINIT: begin
        w.div_init = 1'b1;
        w.tgt_t = S_DSTEP;
      end
      S_DSTEP: begin
        w.div_step = 1'b1;
        w.cond = C_DIV_END;
        w.tgt_t = S_OUT;
        w.tgt_f = S_DSTEP;
      end
      S_LONE: begin
        w.lone_ld = 1'b1;
        w.tgt_t = S_OUT;
      end
      S_OUT: begin
        w.out_ld = 1'b1;
        w.cond = C_OUT_FREE;
        w.tgt_t = S_IDLE;
        w.tgt_f = S_OUT;
      end
      default: begin
        w.tgt_t = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: src/mnnsd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnnsd_if
// Valid/ready channels: point input beats and result output beats.
// ----------------------------------------------------------------------------
interface mnnsd_point_if;
  logic                                valid;
  logic                                ready;
  logic signed [mnnsd_pkg::COORD_W-1:0] pos_x;
  logic signed [mnnsd_pkg::COORD_W-1:0] pos_y;
  logic signed [mnnsd_pkg::COORD_W-1:0] pos_z;
  logic                                last_point;

  modport source (output valid, pos_x, pos_y, pos_z, last_point, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, last_point, output ready);
endinterface

interface mnnsd_result_if;
  logic                               valid;
  logic                               ready;
  logic [mnnsd_pkg::DIST_W-1:0]       mean_sq_dist;
  logic                               lone_point;
  logic                               set_overflow;

  modport source (output valid, mean_sq_dist, lone_point, set_overflow, input ready);
  modport sink (input valid, mean_sq_dist, lone_point, set_overflow, output ready);
endinterface

FILE: src/mnnsd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnnsd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mnnsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/mean_nearest_neighbor_sq_distance_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mean_nearest_neighbor_sq_distance_core
// Point beats are taken only while idle. After the last beat of a set of
// N >= 2 points the core searches every pair, sums the nearest distances,
// divides by N and registers the result; a single point gives the lone result.
// Pairs take the read, difference, square and compare steps and do not overlap.
// Synchronous reset empties the set, clears overflow and drops any pending result.
// ----------------------------------------------------------------------------
module mean_nearest_neighbor_sq_distance_core (
  input  logic                  clk,
  input  logic                  rst,
  mnnsd_point_if.sink           points,
  mnnsd_result_if.source        result
);

  localparam int ADDR_W  = mnnsd_pkg::ADDR_W;
  localparam int CNT_W   = mnnsd_pkg::CNT_W;
  localparam int REM_W   = mnnsd_pkg::REM_W;
  localparam int COORD_W = mnnsd_pkg::COORD_W;
  localparam int POINT_W = mnnsd_pkg::POINT_W;
  localparam int SQ_W    = mnnsd_pkg::SQ_W;
  localparam int DIST_W  = mnnsd_pkg::DIST_W;
  localparam int SUM_W   = mnnsd_pkg::SUM_W;
  localparam int DCNT_W  = mnnsd_pkg::DCNT_W;
  localparam int PC_W    = mnnsd_pkg::PC_W;

  // sequencer
  logic [PC_W-1:0]       pc;
  mnnsd_pkg::ucode_t     uw;
  logic                  cond_hit;
  logic                  beat;

  // load side
  logic [CNT_W-1:0]      point_count;
  logic                  overflow_seen;
  logic                  store_we;

  // search datapath
  logic [CNT_W-1:0]      i_idx;
  logic [CNT_W-1:0]      j_idx;
  logic [ADDR_W-1:0]     raddr;
  logic [POINT_W-1:0]    rdata;
  logic [POINT_W-1:0]    pi;
  logic [COORD_W-1:0]    ad_x, ad_y, ad_z;
  logic [COORD_W-1:0]    ad_x_next, ad_y_next, ad_z_next;
  logic [SQ_W-1:0]       sq_x, sq_y, sq_z;
  logic [DIST_W-1:0]     pair_sq;
  logic [DIST_W-1:0]     best;
  logic [SUM_W-1:0]      sum;

  // restoring divider
  logic [SUM_W-1:0]      quo;
  logic [ADDR_W-1:0]     rem;
  logic [REM_W-1:0]      rem_shift;
  logic [REM_W-1:0]      n_ext;
  logic                  q_bit;
  logic [DCNT_W-1:0]     div_cnt;
  logic                  lone;

  // output register
  logic                  out_valid;
  logic [DIST_W-1:0]     out_mean;
  logic                  out_lone;
  logic                  out_ovf;

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    logic        [COORD_W:0] m;
    d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    m = d[COORD_W] ? (~d + 1'b1) : d;
    return m[COORD_W-1:0];
  endfunction

  assign uw   = mnnsd_pkg::ucode(pc);
  assign beat = points.valid && points.ready;
  assign points.ready = uw.in_rdy;

  always_comb begin
    case (uw.cond)
      mnnsd_pkg::C_ALWAYS:   cond_hit = 1'b1;
      mnnsd_pkg::C_LAST:     cond_hit = beat && points.last_point;
      mnnsd_pkg::C_LONE:     cond_hit = (point_count <= CNT_W'(1));
      mnnsd_pkg::C_J_END:    cond_hit = (j_idx == point_count - 1'b1);
      mnnsd_pkg::C_I_END:    cond_hit = (i_idx == point_count - 1'b1);
      mnnsd_pkg::C_DIV_END:  cond_hit = (div_cnt == DCNT_W'(SUM_W - 1));
      mnnsd_pkg::C_OUT_FREE: cond_hit = !out_valid || result.ready;
      default:               cond_hit = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= mnnsd_pkg::S_IDLE;
    end else begin
      pc <= cond_hit ? uw.tgt_t : uw.tgt_f;
    end
  end

  // point store, written at arrival order while room is left
  assign store_we = beat && (point_count < CNT_W'(mnnsd_pkg::MAX_POINTS));
  assign raddr    = uw.rd_j ? j_idx[ADDR_W-1:0] : i_idx[ADDR_W-1:0];

  mnnsd_ram #(
    .WIDTH (POINT_W),
    .DEPTH (mnnsd_pkg::MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (point_count[ADDR_W-1:0]),
    .wdata ({points.pos_x, points.pos_y, points.pos_z}),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count   <= '0;
      overflow_seen <= 1'b0;
    end else if (uw.out_ld && cond_hit) begin
      point_count   <= '0;
      overflow_seen <= 1'b0;
    end else if (beat) begin
      if (store_we) begin
        point_count <= point_count + 1'b1;
      end else begin
        overflow_seen <= 1'b1;
      end
    end
  end

  assign ad_x_next = abs_diff(pi[POINT_W-1 -: COORD_W], rdata[POINT_W-1 -: COORD_W]);
  assign ad_y_next = abs_diff(pi[2*COORD_W-1 -: COORD_W], rdata[2*COORD_W-1 -: COORD_W]);
  assign ad_z_next = abs_diff(pi[COORD_W-1:0], rdata[COORD_W-1:0]);

  assign pair_sq = DIST_W'(sq_x) + DIST_W'(sq_y) + DIST_W'(sq_z);

  always_ff @(posedge clk) begin
    if (uw.init_i) begin
      i_idx <= '0;
      sum   <= '0;
    end
    if (uw.inc_i) begin
      i_idx <= i_idx + 1'b1;
    end
    if (uw.init_j) begin
      j_idx <= '0;
      best  <= mnnsd_pkg::MEAN_SAT;
    end
    if (uw.inc_j) begin
      j_idx <= j_idx + 1'b1;
    end
    if (uw.ld_pi) begin
      pi <= rdata;
    end
    if (uw.diff_en) begin
      ad_x <= ad_x_next;
      ad_y <= ad_y_next;
      ad_z <= ad_z_next;
    end
    if (uw.sq_en) begin
      sq_x <= ad_x * ad_x;
      sq_y <= ad_y * ad_y;
      sq_z <= ad_z * ad_z;
    end
    // a point is never its own neighbor
    if (uw.cmp_en && (j_idx != i_idx) && (pair_sq < best)) begin
      best <= pair_sq;
    end
    if (uw.acc_en) begin
      sum <= sum + SUM_W'(best);
    end
  end

  // one quotient bit per step, msb first
  assign n_ext     = REM_W'(point_count);
  assign rem_shift = {rem, quo[SUM_W-1]};
  assign q_bit     = (rem_shift >= n_ext);

  always_ff @(posedge clk) begin
    if (uw.div_init) begin
      quo     <= sum;
      rem     <= '0;
      div_cnt <= '0;
      lone    <= 1'b0;
    end
    if (uw.div_step) begin
      quo     <= {quo[SUM_W-2:0], q_bit};
      rem     <= q_bit ? ADDR_W'(rem_shift - n_ext) : rem_shift[ADDR_W-1:0];
      div_cnt <= div_cnt + 1'b1;
    end
    if (uw.lone_ld) begin
      quo  <= SUM_W'(mnnsd_pkg::MEAN_SAT);
      lone <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uw.out_ld && cond_hit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.out_ld && cond_hit) begin
      out_mean <= quo[DIST_W-1:0];
      out_lone <= lone;
      out_ovf  <= overflow_seen;
    end
  end

  assign result.valid        = out_valid;
  assign result.mean_sq_dist = out_mean;
  assign result.lone_point   = out_lone;
  assign result.set_overflow = out_ovf;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= CNT_W'(mnnsd_pkg::MAX_POINTS))
    else $error("point count beyond storage");

  a_lone_sat: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.lone_point) |-> (result.mean_sq_dist == mnnsd_pkg::MEAN_SAT))
    else $error("lone point result not saturated");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (pc == mnnsd_pkg::S_DSTEP) |-> (point_count >= CNT_W'(2)))
    else $error("division with fewer than two points");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    (pc != mnnsd_pkg::S_IDLE) |=> $stable(point_count) || (point_count == '0))
    else $error("point count changed during search");

endmodule
